### rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers on clk; MF_ASSERT off while rst_n low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MF_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MF_ASSERT(lbl, prop, msg)
`define MF_ASSERT_RST(lbl, prop, msg)
`endif
`endif

### rtl/mf5_pkg.sv
// ---------------------------------------------------------------------------
// mf5_pkg
// Types and constants of the 5x5 median filter.
// ---------------------------------------------------------------------------
package mf5_pkg;
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int WIN       = 5;
  localparam int WIN_N     = WIN * WIN;
  localparam int MED_RANK  = 12;
  localparam int MIN_DIM   = 5;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);
endpackage

### rtl/mf5_in_if.sv
// ---------------------------------------------------------------------------
// mf5_in_if
// Input channel: one pixel or drain tick per transaction.
// ---------------------------------------------------------------------------
interface mf5_in_if;
  logic valid;
  logic ready;
  logic func;
  mf5_pkg::pix_t pixel;
  modport source (output valid, output func, output pixel, input ready);
  modport sink (input valid, input func, input pixel, output ready);
endinterface

### rtl/mf5_out_if.sv
// ---------------------------------------------------------------------------
// mf5_out_if
// Result channel: one filtered pixel per transaction.
// ---------------------------------------------------------------------------
interface mf5_out_if;
  logic valid;
  logic ready;
  mf5_pkg::pix_t median;
  logic frame_end;
  modport source (output valid, output median, output frame_end, input ready);
  modport sink (input valid, input median, input frame_end, output ready);
endinterface

### rtl/mf5_ram.sv
// ---------------------------------------------------------------------------
// mf5_ram
// Simple dual-port RAM, one write port and one registered read port.
// ---------------------------------------------------------------------------
module mf5_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

### rtl/median_filter_5x5.sv
// The result that an accepted transaction releases passes through stages s1,
// s2, s3 and s4 and then the output register. Throughput: one transaction per
// cycle; the whole pipeline holds while a result waits at the output. The
// output lags the raster by 2*W+2 positions held in four line RAMs, which
// reset does not clear. Reset (rst_n low, synchronous) clears counters and
// valid bits and sets frame_width to min(320, MAX_LINE) and frame_height to min(240, MAX_LINES).
// ---------------------------------------------------------------------------
// median_filter_5x5
// Streaming 5x5 median filter with zero padding outside the frame.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module median_filter_5x5 #(
  parameter int MAX_LINE  = 1024,
  parameter int MAX_LINES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  mf5_pkg::cfg_idx_t        cfg_index,
  input  logic [mf5_pkg::CFG_W-1:0] cfg_data,
  mf5_in_if.sink                   in_ch,
  mf5_out_if.source                out_ch
);
  localparam int CW = $clog2(MAX_LINE);
  localparam int RW = $clog2(MAX_LINES + 3);
  localparam int PW = mf5_pkg::PIX_W;
  localparam int N  = mf5_pkg::WIN_N;
  localparam int RST_W = (MAX_LINE < 320) ? MAX_LINE : 320;
  localparam int RST_H = (MAX_LINES < 240) ? MAX_LINES : 240;
  localparam logic [31:0] MAXW = 32'(MAX_LINE);
  localparam logic [31:0] MAXH = 32'(MAX_LINES);
  localparam logic [31:0] MIND = 32'(mf5_pkg::MIN_DIM);

  logic [CW:0]   w_r;
  logic [RW-1:0] h_r;
  logic [CW-1:0] cx_r;
  logic [RW-1:0] cy_r;

  logic adv, accept;
  logic [31:0] cfg_wide;
  logic [31:0] cfg_held_w, cfg_held_h;

  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  logic [CW:0]   cx_inc;
  logic [RW:0]   cy_ext;
  mf5_pkg::pix_t v;
  logic          have0, last0, fe0;
  logic [CW-1:0] ox0;
  logic [RW-1:0] oy0;

  logic          s1_valid_r, s1_have_r, s1_fe_r;
  mf5_pkg::pix_t s1_v_r;
  logic [CW-1:0] s1_cx_r, s1_ox_r;
  logic [RW-1:0] s1_oy_r;
  mf5_pkg::pix_t rd [4];

  mf5_pkg::pix_t win_r [mf5_pkg::WIN][mf5_pkg::WIN];
  logic          s2_valid_r, s2_fe_r;
  logic [CW-1:0] s2_ox_r;
  logic [RW-1:0] s2_oy_r;
  logic [mf5_pkg::WIN-1:0] xok, yok;

  mf5_pkg::pix_t s3_val_r [N];
  logic          s3_valid_r, s3_fe_r;
  logic [N-1:0]  sel_nxt;

  mf5_pkg::pix_t s4_val_r [N];
  logic [N-1:0]  s4_sel_r;
  logic          s4_valid_r, s4_fe_r;
  mf5_pkg::pix_t med_nxt;

  logic          out_valid_r, out_fe_r;
  mf5_pkg::pix_t out_med_r;

  assign adv    = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && adv;
  assign in_ch.ready = adv;

  assign cfg_wide   = {{(32 - mf5_pkg::CFG_W){1'b0}}, cfg_data};
  assign cfg_held_w = (cfg_wide < MIND) ? MIND : ((cfg_wide > MAXW) ? MAXW : cfg_wide);
  assign cfg_held_h = (cfg_wide < MIND) ? MIND : ((cfg_wide > MAXH) ? MAXH : cfg_wide);

  always_comb begin
    cx = cx_r;
    cy = cy_r;
    if (({1'b0, cx_r} >= w_r) || ({1'b0, cy_r} > ({1'b0, h_r} + (RW+1)'(2)))) begin
      cx = '0;
      cy = '0;
    end
    cy_ext = {1'b0, cy};
    v = in_ch.func ? '0 : in_ch.pixel;
    if (cy >= h_r) begin
      v = '0;
    end
    if (cx >= CW'(2)) begin
      ox0   = cx - CW'(2);
      oy0   = cy - RW'(2);
      have0 = (cy >= RW'(2)) && (cy_ext - (RW+1)'(2) < {1'b0, h_r});
    end else begin
      ox0   = CW'(w_r - (CW+1)'(2) + {1'b0, cx});
      oy0   = cy - RW'(3);
      have0 = (cy >= RW'(3)) && (cy_ext - (RW+1)'(3) < {1'b0, h_r});
    end
    fe0    = ({1'b0, ox0} == w_r - (CW+1)'(1)) && (oy0 == h_r - RW'(1));
    last0  = (cy_ext >= {1'b0, h_r} + (RW+1)'(2)) && (cx >= CW'(1));
    cx_inc = {1'b0, cx} + (CW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r  <= (CW+1)'(RST_W);
      h_r  <= RW'(RST_H);
      cx_r <= '0;
      cy_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mf5_pkg::REG_FRAME_WIDTH:  w_r <= (CW+1)'(cfg_held_w);
        mf5_pkg::REG_FRAME_HEIGHT: h_r <= RW'(cfg_held_h);
        default: ;
      endcase
      cx_r <= '0;
      cy_r <= '0;
    end else if (accept) begin
      if (last0) begin
        cx_r <= '0;
        cy_r <= '0;
      end else if (cx_inc >= w_r) begin
        cx_r <= '0;
        cy_r <= cy + RW'(1);
      end else begin
        cx_r <= CW'(cx_inc);
        cy_r <= cy;
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_line
    mf5_ram #(.WIDTH(PW), .DEPTH(MAX_LINE)) u_line (
      .clk   (clk),
      .we    (adv && s1_valid_r),
      .waddr (s1_cx_r),
      .wdata ((g == 0) ? s1_v_r : rd[(g == 0) ? 0 : g - 1]),
      .re    (accept),
      .raddr (cx),
      .rdata (rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r && s1_have_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  always_comb begin
    xok[0] = {1'b0, s2_ox_r} + (CW+1)'(2) < w_r;
    xok[1] = {1'b0, s2_ox_r} + (CW+1)'(1) < w_r;
    xok[2] = 1'b1;
    xok[3] = s2_ox_r >= CW'(1);
    xok[4] = s2_ox_r >= CW'(2);
    yok[0] = {1'b0, s2_oy_r} + (RW+1)'(2) < {1'b0, h_r};
    yok[1] = {1'b0, s2_oy_r} + (RW+1)'(1) < {1'b0, h_r};
    yok[2] = 1'b1;
    yok[3] = s2_oy_r >= RW'(1);
    yok[4] = s2_oy_r >= RW'(2);
  end

  always_comb begin
    logic [N-1:0] lt;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt[j] = (s3_val_r[j] < s3_val_r[i]) || ((s3_val_r[j] == s3_val_r[i]) && (j < i));
      end
      sel_nxt[i] = ($countones(lt) == mf5_pkg::MED_RANK);
    end
  end

  always_comb begin
    med_nxt = '0;
    for (int i = 0; i < N; i++) begin
      med_nxt = med_nxt | (s4_val_r[i] & {PW{s4_sel_r[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_v_r  <= v;
      s1_cx_r <= cx;
      s1_ox_r <= ox0;
      s1_oy_r <= oy0;
      s1_have_r <= have0;
      s1_fe_r <= fe0;
      if (s1_valid_r) begin
        win_r[0][0] <= s1_v_r;
        for (int r = 1; r < mf5_pkg::WIN; r++) begin
          win_r[0][r] <= rd[r-1];
        end
        for (int m = 1; m < mf5_pkg::WIN; m++) begin
          win_r[m] <= win_r[m-1];
        end
      end
      s2_ox_r <= s1_ox_r;
      s2_oy_r <= s1_oy_r;
      s2_fe_r <= s1_fe_r;
      for (int m = 0; m < mf5_pkg::WIN; m++) begin
        for (int r = 0; r < mf5_pkg::WIN; r++) begin
          s3_val_r[m*mf5_pkg::WIN + r] <= (xok[m] && yok[r]) ? win_r[m][r] : '0;
        end
      end
      s3_fe_r   <= s2_fe_r;
      s4_val_r  <= s3_val_r;
      s4_sel_r  <= sel_nxt;
      s4_fe_r   <= s3_fe_r;
      out_med_r <= med_nxt;
      out_fe_r  <= s4_fe_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.median    = out_med_r;
  assign out_ch.frame_end = out_fe_r;

  `MF_ASSERT(a_line_rw_apart, (accept && s1_valid_r) |-> (s1_cx_r != cx), "line RAM read and write collide")
  `MF_ASSERT(a_col_in_range, ({1'b0, cx_r} <= w_r), "column counter beyond line width")
  `MF_ASSERT(a_median_onehot, s4_valid_r |-> $onehot(s4_sel_r), "median select not one-hot")
  `MF_ASSERT_RST(a_reset_empty, $past(!rst_n) |-> !out_valid_r, "output valid right after reset")
endmodule
